// ===== hw/rtl/tdec_pkg.sv =====
// Shared types and constants for the two-disc collision pipeline.
package tdec_pkg;

  localparam int CW = 24;          // coordinate width
  localparam int FB = 16;          // coordinate fraction bits
  localparam int SCALE_FRAC = 12;  // detect_scale fraction bits
  localparam logic [15:0] DETECT_SCALE_RST = 16'd9216;

  typedef struct packed {
    logic signed [CW-1:0] pos_a_x;
    logic signed [CW-1:0] pos_a_z;
    logic signed [CW-1:0] vel_a_x;
    logic signed [CW-1:0] vel_a_z;
    logic signed [CW-1:0] pos_b_x;
    logic signed [CW-1:0] pos_b_z;
    logic signed [CW-1:0] vel_b_x;
    logic signed [CW-1:0] vel_b_z;
    logic [15:0]          mass_a;
    logic [15:0]          mass_b;
    logic [15:0]          radius_a;
    logic [15:0]          radius_b;
  } coll_in_t;

  typedef struct packed {
    logic signed [CW-1:0] new_pos_a_x;
    logic signed [CW-1:0] new_pos_a_z;
    logic signed [CW-1:0] new_vel_a_x;
    logic signed [CW-1:0] new_vel_a_z;
    logic signed [CW-1:0] new_pos_b_x;
    logic signed [CW-1:0] new_pos_b_z;
    logic signed [CW-1:0] new_vel_b_x;
    logic signed [CW-1:0] new_vel_b_z;
    logic                 in_contact;
    logic                 impulse_applied;
  } coll_out_t;

endpackage

// ===== hw/rtl/tdec_sqrt.sv =====
// Pipelined integer square root, two radicand bits per stage.
module tdec_sqrt #(
  parameter int QW = 50,
  parameter int SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [QW-1:0]     rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [QW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int RW = QW / 2;

  logic          vld_q  [RW];
  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [QW-1:0] rad_q  [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          vld_p;
    logic [RW+1:0] rem_p;
    logic [RW-1:0] root_p;
    logic [QW-1:0] rad_p;
    logic [SW-1:0] side_p;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign side_p = side_i;
    end else begin : g_rest
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign cur   = {rem_p[RW-1:0], rad_p[QW-1:QW-2]};
    assign trial = {root_p, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (cur - trial) : cur;
        root_q[k] <= {root_p[RW-2:0], ge};
        rad_q[k]  <= {rad_p[QW-3:0], 2'b00};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ===== hw/rtl/tdec_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tdec_div #(
  parameter int DW = 17,
  parameter int NB = 26,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,   // upper part of the dividend, below den_i
  input  logic [NB-1:0] num_i,   // lower dividend bits, shifted in msb first
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NB-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [NB];
  logic [DW-1:0] den_q  [NB];
  logic [DW-1:0] rem_q  [NB];
  logic [NB-1:0] num_q  [NB];
  logic [NB-1:0] quo_q  [NB];
  logic [SW-1:0] side_q [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic          vld_p;
    logic [DW-1:0] den_p;
    logic [DW-1:0] rem_p;
    logic [NB-1:0] num_p;
    logic [NB-1:0] quo_p;
    logic [SW-1:0] side_p;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign den_p  = den_i;
      assign rem_p  = rem_i;
      assign num_p  = num_i;
      assign quo_p  = '0;
      assign side_p = side_i;
    end else begin : g_rest
      assign vld_p  = vld_q[k-1];
      assign den_p  = den_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign num_p  = num_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign cur  = {rem_p, num_p[NB-1]};
    assign diff = cur - {1'b0, den_p};
    assign ge   = (cur >= {1'b0, den_p});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_p;
        rem_q[k]  <= ge ? diff[DW-1:0] : cur[DW-1:0];
        num_q[k]  <= {num_p[NB-2:0], 1'b0};
        quo_q[k]  <= {quo_p[NB-2:0], ge};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[NB-1];
  assign quo_o   = quo_q[NB-1];
  assign side_o  = side_q[NB-1];

endmodule

// ===== hw/rtl/two_disc_elastic_collision.sv =====
// Two-disc collision check and elastic response, fully pipelined.
//
// Input channel: in_valid_i / in_stall_o carry one disc pair per beat in
// in_data_i. Output channel: out_valid_o / out_stall_i carry one result beat
// per input beat, in order, on out_data_o.
// A new pair is taken every cycle while the output is not stalled. The
// pipeline holds three setup stages, a 25-stage square root, a 16-stage
// divider for the unit normal, seven stages of products and sums, a 26-stage
// divider for the elastic exchange, two stages of velocity update and the
// output register.
// The whole pipeline advances as one; while a result waits at the output
// under stall, in_stall_o is high and no stage moves, so nothing is lost or
// repeated.
// detect_scale is written with cfg_we_i / cfg_data_i; the user must write it
// only while the pipeline is empty, which the block itself does not enforce.
// Reset clears every valid bit and loads detect_scale with 2.25 (Q4.12).
module two_disc_elastic_collision (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tdec_pkg::coll_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tdec_pkg::coll_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int CW  = tdec_pkg::CW;
  localparam int FB  = tdec_pkg::FB;
  localparam int DXW = CW + 1;       // coordinate difference
  localparam int QW  = 2 * DXW;      // squared distance
  localparam int NRW = FB + 2;       // normal component, +-1.0
  localparam int VNW = CW + 3;       // normal velocity
  localparam int NMW = 46;           // impulse numerator
  localparam int QDW = 26;           // impulse quotient bits
  localparam logic signed [NRW-1:0] ONE = NRW'(1) <<< FB;
  localparam logic signed [31:0] SAT_HI = 32'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

  typedef struct packed {
    tdec_pkg::coll_in_t     din;
    logic signed [DXW-1:0]  dx;
    logic signed [DXW-1:0]  dz;
    logic signed [DXW-1:0]  dvx;
    logic signed [DXW-1:0]  dvz;
    logic [15:0]            ma;
    logic [15:0]            mb;
    logic signed [16:0]     mdiff;
    logic signed [16:0]     mdiffn;
    logic [16:0]            msum;
    logic [16:0]            rsum;
  } common_t;

  typedef struct packed {
    common_t c;
    logic    contact;
    logic    ovl;
    logic    zero;
  } side_a_t;

  typedef struct packed {
    side_a_t          a;
    logic [DXW-1:0]   root;
    logic             clampx;
    logic             clampz;
  } side_b_t;

  typedef struct packed {
    tdec_pkg::coll_in_t     din;
    logic signed [NRW-1:0]  nx;
    logic signed [NRW-1:0]  nz;
    logic [15:0]            ma;
    logic [15:0]            mb;
    logic signed [16:0]     mdiff;
    logic signed [16:0]     mdiffn;
    logic [16:0]            msum;
    logic                   contact;
    logic                   ovl;
  } base_t;

  typedef struct packed {
    logic signed [CW-1:0] pax;
    logic signed [CW-1:0] paz;
    logic signed [CW-1:0] pbx;
    logic signed [CW-1:0] pbz;
  } pos_t;

  typedef struct packed {
    tdec_pkg::coll_in_t     din;
    pos_t                   pos;
    logic signed [VNW-1:0]  van;
    logic signed [VNW-1:0]  vbn;
    logic signed [NRW-1:0]  nx;
    logic signed [NRW-1:0]  nz;
    logic                   contact;
    logic                   impulse;
    logic                   sgna;
  } side_d_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [31:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_HI) begin
      r = CW'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = CW'(SAT_LO);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  logic        en;
  logic        out_valid_q;
  logic [15:0] scale_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= tdec_pkg::DETECT_SCALE_RST;
    end else if (cfg_we_i) begin
      scale_q <= cfg_data_i;
    end
  end

  // ---------------- setup stages ----------------
  logic        v1_q, v2_q, v3_q;
  common_t     c1_q, c2_q, c3_q;
  logic [20:0] thr1_q;
  logic [31:0] rbs;
  logic [15:0] ma_fix, mb_fix;
  logic [QW-2:0] dxsq2_q, dzsq2_q;
  logic [41:0] thsq2_q;
  logic [33:0] rssq2_q;
  logic [QW-1:0] q3_q;
  logic          contact3_q, ovl3_q, zero3_q;
  logic signed [QW-1:0] dxsq, dzsq;
  logic [QW-1:0] qsum;

  assign rbs    = 32'(in_data_i.radius_b) * 32'(scale_q);
  assign ma_fix = (in_data_i.mass_a == 16'd0) ? 16'd1 : in_data_i.mass_a;
  assign mb_fix = (in_data_i.mass_b == 16'd0) ? 16'd1 : in_data_i.mass_b;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q.din    <= in_data_i;
      c1_q.dx     <= DXW'(in_data_i.pos_b_x) - DXW'(in_data_i.pos_a_x);
      c1_q.dz     <= DXW'(in_data_i.pos_b_z) - DXW'(in_data_i.pos_a_z);
      c1_q.dvx    <= DXW'(in_data_i.vel_b_x) - DXW'(in_data_i.vel_a_x);
      c1_q.dvz    <= DXW'(in_data_i.vel_b_z) - DXW'(in_data_i.vel_a_z);
      c1_q.ma     <= ma_fix;
      c1_q.mb     <= mb_fix;
      c1_q.mdiff  <= $signed({1'b0, ma_fix}) - $signed({1'b0, mb_fix});
      c1_q.mdiffn <= $signed({1'b0, mb_fix}) - $signed({1'b0, ma_fix});
      c1_q.msum   <= 17'(ma_fix) + 17'(mb_fix);
      c1_q.rsum   <= 17'(in_data_i.radius_a) + 17'(in_data_i.radius_b);
      thr1_q      <= 21'(in_data_i.radius_a) + 21'(rbs >> tdec_pkg::SCALE_FRAC);
    end
  end

  assign dxsq = c1_q.dx * c1_q.dx;
  assign dzsq = c1_q.dz * c1_q.dz;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q    <= c1_q;
      dxsq2_q <= dxsq[QW-2:0];
      dzsq2_q <= dzsq[QW-2:0];
      thsq2_q <= 42'(thr1_q) * 42'(thr1_q);
      rssq2_q <= 34'(c1_q.rsum) * 34'(c1_q.rsum);
    end
  end

  assign qsum = QW'(dxsq2_q) + QW'(dzsq2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q       <= c2_q;
      q3_q       <= qsum;
      contact3_q <= (qsum < QW'(thsq2_q));
      ovl3_q     <= (qsum < QW'(rssq2_q));
      zero3_q    <= (qsum == '0);
    end
  end

  // ---------------- distance ----------------
  side_a_t        sa_in, sa_out;
  logic           sq_valid;
  logic [DXW-1:0] root;

  assign sa_in = '{c: c3_q, contact: contact3_q, ovl: ovl3_q, zero: zero3_q};

  tdec_sqrt #(.QW(QW), .SW($bits(side_a_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (q3_q),
    .side_i  (sa_in),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sa_out)
  );

  // ---------------- unit normal ----------------
  logic [DXW-1:0] absdx, absdz;
  side_b_t        sb_in, sb_out;
  logic           dvx_valid, dvz_valid;
  logic [FB-1:0]  qx, qz;
  logic           dz_neg;

  assign absdx = sa_out.c.dx[DXW-1] ? DXW'(-sa_out.c.dx) : DXW'(sa_out.c.dx);
  assign absdz = sa_out.c.dz[DXW-1] ? DXW'(-sa_out.c.dz) : DXW'(sa_out.c.dz);
  assign sb_in = '{a: sa_out, root: root, clampx: (absdx >= root),
                   clampz: (absdz >= root)};

  tdec_div #(.DW(DXW), .NB(FB), .SW($bits(side_b_t))) u_div_nx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .den_i   (root),
    .rem_i   (sb_in.clampx ? '0 : absdx),
    .num_i   ('0),
    .side_i  (sb_in),
    .valid_o (dvx_valid),
    .quo_o   (qx),
    .side_o  (sb_out)
  );

  tdec_div #(.DW(DXW), .NB(FB), .SW(1)) u_div_nz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .den_i   (root),
    .rem_i   (sb_in.clampz ? '0 : absdz),
    .num_i   ('0),
    .side_i  (sa_out.c.dz[DXW-1]),
    .valid_o (dvz_valid),
    .quo_o   (qz),
    .side_o  (dz_neg)
  );

  // ---------------- normal, products, sums ----------------
  logic [6:0]             vn_q;
  base_t                  b1_q, b2_q, b3_q, b4_q, b5_q, b6_q, b7_q;
  logic signed [DXW-1:0]  dvx1_q, dvz1_q;
  logic [16:0]            ov1_q;
  logic signed [NRW-1:0]  magx, magz;
  logic signed [35:0]     pcx2_q, pcz2_q;
  logic signed [42:0]     rx2_q, rz2_q;
  logic signed [41:0]     ax2_q, az2_q, bx2_q, bz2_q;
  logic signed [43:0]     rel3_q;
  logic signed [42:0]     sa3_q, sb3_q;
  logic signed [35:0]     cxs, czs;
  logic signed [18:0]     cx3_q, cz3_q;
  logic signed [42:0]     vans, vbns;
  logic signed [VNW-1:0]  van4_q, vbn4_q;
  logic                   imp4_q;
  pos_t                   pos4_q, pos5_q, pos6_q, pos7_q;
  logic signed [18:0]     cxe, cze;
  logic signed [VNW-1:0]  van5_q, vbn5_q, van6_q, vbn6_q, van7_q, vbn7_q;
  logic                   imp5_q, imp6_q, imp7_q;
  logic signed [43:0]     ta5_q, tb5_q, tc5_q, td5_q;
  logic signed [NMW-1:0]  numa6_q, numb6_q;
  logic [NMW-1:0]         absa7_q, absb7_q;
  logic                   sgna7_q, sgnb7_q;

  assign magx = sb_out.clampx ? ONE : NRW'(qx);
  assign magz = sb_out.clampz ? ONE : NRW'(qz);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q.din     <= sb_out.a.c.din;
      b1_q.nx      <= sb_out.a.zero ? ONE :
                      (sb_out.a.c.dx[DXW-1] ? -magx : magx);
      b1_q.nz      <= sb_out.a.zero ? '0 : (dz_neg ? -magz : magz);
      b1_q.ma      <= sb_out.a.c.ma;
      b1_q.mb      <= sb_out.a.c.mb;
      b1_q.mdiff   <= sb_out.a.c.mdiff;
      b1_q.mdiffn  <= sb_out.a.c.mdiffn;
      b1_q.msum    <= sb_out.a.c.msum;
      b1_q.contact <= sb_out.a.contact;
      b1_q.ovl     <= sb_out.a.ovl;
      dvx1_q       <= sb_out.a.c.dvx;
      dvz1_q       <= sb_out.a.c.dvz;
      // only used under overlap, where root < rsum
      ov1_q        <= sb_out.a.c.rsum - sb_out.root[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q   <= b1_q;
      pcx2_q <= $signed({1'b0, ov1_q}) * b1_q.nx;
      pcz2_q <= $signed({1'b0, ov1_q}) * b1_q.nz;
      rx2_q  <= dvx1_q * b1_q.nx;
      rz2_q  <= dvz1_q * b1_q.nz;
      ax2_q  <= b1_q.din.vel_a_x * b1_q.nx;
      az2_q  <= b1_q.din.vel_a_z * b1_q.nz;
      bx2_q  <= b1_q.din.vel_b_x * b1_q.nx;
      bz2_q  <= b1_q.din.vel_b_z * b1_q.nz;
    end
  end

  assign cxs = pcx2_q >>> (FB + 1);
  assign czs = pcz2_q >>> (FB + 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_q   <= b2_q;
      rel3_q <= 44'(rx2_q) + 44'(rz2_q);
      sa3_q  <= 43'(ax2_q) + 43'(az2_q);
      sb3_q  <= 43'(bx2_q) + 43'(bz2_q);
      cx3_q  <= cxs[18:0];
      cz3_q  <= czs[18:0];
    end
  end

  assign vans = sa3_q >>> FB;
  assign vbns = sb3_q >>> FB;
  assign cxe  = (b3_q.contact && b3_q.ovl) ? cx3_q : '0;
  assign cze  = (b3_q.contact && b3_q.ovl) ? cz3_q : '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b4_q       <= b3_q;
      van4_q     <= vans[VNW-1:0];
      vbn4_q     <= vbns[VNW-1:0];
      imp4_q     <= b3_q.contact && (rel3_q <= 44'sd0);
      pos4_q.pax <= sat(32'(b3_q.din.pos_a_x) - 32'(cxe));
      pos4_q.paz <= sat(32'(b3_q.din.pos_a_z) - 32'(cze));
      pos4_q.pbx <= sat(32'(b3_q.din.pos_b_x) + 32'(cxe));
      pos4_q.pbz <= sat(32'(b3_q.din.pos_b_z) + 32'(cze));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b5_q   <= b4_q;
      pos5_q <= pos4_q;
      van5_q <= van4_q;
      vbn5_q <= vbn4_q;
      imp5_q <= imp4_q;
      ta5_q  <= van4_q * b4_q.mdiff;
      tb5_q  <= vbn4_q * $signed({1'b0, b4_q.mb});
      tc5_q  <= vbn4_q * b4_q.mdiffn;
      td5_q  <= van4_q * $signed({1'b0, b4_q.ma});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b6_q    <= b5_q;
      pos6_q  <= pos5_q;
      van6_q  <= van5_q;
      vbn6_q  <= vbn5_q;
      imp6_q  <= imp5_q;
      numa6_q <= NMW'(ta5_q) + (NMW'(tb5_q) <<< 1);
      numb6_q <= NMW'(tc5_q) + (NMW'(td5_q) <<< 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b7_q    <= b6_q;
      pos7_q  <= pos6_q;
      van7_q  <= van6_q;
      vbn7_q  <= vbn6_q;
      imp7_q  <= imp6_q;
      sgna7_q <= numa6_q[NMW-1];
      sgnb7_q <= numb6_q[NMW-1];
      absa7_q <= numa6_q[NMW-1] ? NMW'(-numa6_q) : NMW'(numa6_q);
      absb7_q <= numb6_q[NMW-1] ? NMW'(-numb6_q) : NMW'(numb6_q);
    end
  end

  // ---------------- elastic exchange ----------------
  side_d_t        sd_in, sd_out;
  logic           ea_valid, eb_valid;
  logic [QDW-1:0] qa, qb;
  logic           sgnb;

  assign sd_in = '{din: b7_q.din, pos: pos7_q, van: van7_q, vbn: vbn7_q,
                   nx: b7_q.nx, nz: b7_q.nz, contact: b7_q.contact,
                   impulse: imp7_q, sgna: sgna7_q};

  // |numerator| < 2^QDW * msum, so the upper bits start below the divisor
  tdec_div #(.DW(17), .NB(QDW), .SW($bits(side_d_t))) u_div_va (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vn_q[6]),
    .den_i   (b7_q.msum),
    .rem_i   (absa7_q[QDW+16:QDW]),
    .num_i   (absa7_q[QDW-1:0]),
    .side_i  (sd_in),
    .valid_o (ea_valid),
    .quo_o   (qa),
    .side_o  (sd_out)
  );

  tdec_div #(.DW(17), .NB(QDW), .SW(1)) u_div_vb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vn_q[6]),
    .den_i   (b7_q.msum),
    .rem_i   (absb7_q[QDW+16:QDW]),
    .num_i   (absb7_q[QDW-1:0]),
    .side_i  (sgnb7_q),
    .valid_o (eb_valid),
    .quo_o   (qb),
    .side_o  (sgnb)
  );

  // ---------------- velocity update ----------------
  logic [1:0]             vd_q;
  side_d_t                d1_q, d2_q;
  logic signed [VNW:0]    da1_q, db1_q;
  logic signed [VNW-1:0]  van2, vbn2;
  logic signed [45:0]     ex2_q, ez2_q, fx2_q, fz2_q;
  logic signed [45:0]     exs, ezs, fxs, fzs;
  tdec_pkg::coll_out_t    out_q;

  assign van2 = sd_out.sgna ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
  assign vbn2 = sgnb ? -$signed({1'b0, qb}) : $signed({1'b0, qb});

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q  <= sd_out;
      da1_q <= (VNW+1)'(van2) - (VNW+1)'(sd_out.van);
      db1_q <= (VNW+1)'(vbn2) - (VNW+1)'(sd_out.vbn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q  <= d1_q;
      ex2_q <= da1_q * d1_q.nx;
      ez2_q <= da1_q * d1_q.nz;
      fx2_q <= db1_q * d1_q.nx;
      fz2_q <= db1_q * d1_q.nz;
    end
  end

  assign exs = ex2_q >>> FB;
  assign ezs = ez2_q >>> FB;
  assign fxs = fx2_q >>> FB;
  assign fzs = fz2_q >>> FB;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.new_pos_a_x <= d2_q.pos.pax;
      out_q.new_pos_a_z <= d2_q.pos.paz;
      out_q.new_pos_b_x <= d2_q.pos.pbx;
      out_q.new_pos_b_z <= d2_q.pos.pbz;
      out_q.new_vel_a_x <= d2_q.impulse ?
                           sat(32'(d2_q.din.vel_a_x) + 32'(exs)) : d2_q.din.vel_a_x;
      out_q.new_vel_a_z <= d2_q.impulse ?
                           sat(32'(d2_q.din.vel_a_z) + 32'(ezs)) : d2_q.din.vel_a_z;
      out_q.new_vel_b_x <= d2_q.impulse ?
                           sat(32'(d2_q.din.vel_b_x) + 32'(fxs)) : d2_q.din.vel_b_x;
      out_q.new_vel_b_z <= d2_q.impulse ?
                           sat(32'(d2_q.din.vel_b_z) + 32'(fzs)) : d2_q.din.vel_b_z;
      out_q.in_contact      <= d2_q.contact;
      out_q.impulse_applied <= d2_q.impulse;
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      vn_q        <= '0;
      vd_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      vn_q        <= {vn_q[5:0], dvx_valid && dvz_valid};
      vd_q        <= {vd_q[0], ea_valid && eb_valid};
      out_valid_q <= vd_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- checks ----------------
  a_impulse_needs_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.impulse_applied || out_q.in_contact))
    else $error("impulse flagged without contact");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vn_q[0] |-> (b1_q.nx <= ONE && b1_q.nx >= -ONE && b1_q.nz <= ONE && b1_q.nz >= -ONE))
    else $error("normal component beyond unit range");

  a_div_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dvx_valid == dvz_valid) && (ea_valid == eb_valid))
    else $error("parallel divider lanes out of step");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable({v1_q, v2_q, v3_q, vn_q, vd_q}))
    else $error("pipeline moved while output stalled");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the two-disc elastic collision pipeline.
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY = 80;
  localparam int N_RAND = 1450;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = -24'sh800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tdec_pkg::coll_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tdec_pkg::coll_out_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  always #4 clk = ~clk;

  two_disc_elastic_collision DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data)
  );

  logic [15:0] scale_q = tdec_pkg::DETECT_SCALE_RST;
  tdec_pkg::coll_out_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int contacts_seen = 0;
  int impulses_seen = 0;
  longint cycles = 0;
  bit hold_long = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v[23:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned q);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic tdec_pkg::coll_out_t collide(tdec_pkg::coll_in_t p, logic [15:0] scl);
    tdec_pkg::coll_out_t o;
    longint pax, paz, vax, vaz, pbx, pbz, vbx, vbz, ma, mb, ra, rb;
    longint dx, dz, q, thr, d, nx, nz, s, ov, cx, cz, rel;
    longint van, vbn, msum, van2, vbn2, da, db;
    longint one = 64'sd1 <<< tdec_pkg::FB;
    pax = p.pos_a_x; paz = p.pos_a_z; vax = p.vel_a_x; vaz = p.vel_a_z;
    pbx = p.pos_b_x; pbz = p.pos_b_z; vbx = p.vel_b_x; vbz = p.vel_b_z;
    ma = p.mass_a; mb = p.mass_b; ra = p.radius_a; rb = p.radius_b;
    if (ma == 0) ma = 1;
    if (mb == 0) mb = 1;
    dx = pbx - pax; dz = pbz - paz;
    q = dx * dx + dz * dz;
    thr = ra + ((rb * longint'(scl)) >>> tdec_pkg::SCALE_FRAC);
    o.in_contact = 1'b0;
    o.impulse_applied = 1'b0;
    if (q < thr * thr) begin
      o.in_contact = 1'b1;
      d = int_sqrt(q);
      if (q == 0) begin
        nx = one; nz = 0;
      end else begin
        nx = dx * one / d; nz = dz * one / d;
        if (nx > one) nx = one;
        if (nx < -one) nx = -one;
        if (nz > one) nz = one;
        if (nz < -one) nz = -one;
      end
      s = ra + rb;
      if (q < s * s) begin
        ov = s - d;
        cx = floor_shr(ov * nx, tdec_pkg::FB + 1);
        cz = floor_shr(ov * nz, tdec_pkg::FB + 1);
        pax -= cx; paz -= cz; pbx += cx; pbz += cz;
      end
      rel = (vbx - vax) * nx + (vbz - vaz) * nz;
      if (rel <= 0) begin
        van = floor_shr(vax * nx + vaz * nz, tdec_pkg::FB);
        vbn = floor_shr(vbx * nx + vbz * nz, tdec_pkg::FB);
        msum = ma + mb;
        van2 = (van * (ma - mb) + 2 * mb * vbn) / msum;
        vbn2 = (vbn * (mb - ma) + 2 * ma * van) / msum;
        da = van2 - van; db = vbn2 - vbn;
        vax += floor_shr(da * nx, tdec_pkg::FB); vaz += floor_shr(da * nz, tdec_pkg::FB);
        vbx += floor_shr(db * nx, tdec_pkg::FB); vbz += floor_shr(db * nz, tdec_pkg::FB);
        o.impulse_applied = 1'b1;
      end
    end
    o.new_pos_a_x = clamp24(pax); o.new_pos_a_z = clamp24(paz);
    o.new_vel_a_x = clamp24(vax); o.new_vel_a_z = clamp24(vaz);
    o.new_pos_b_x = clamp24(pbx); o.new_pos_b_z = clamp24(pbz);
    o.new_vel_b_x = clamp24(vbx); o.new_vel_b_z = clamp24(vbz);
    return o;
  endfunction

  // directed rows: pair, and a typed expectation where it is obvious
  typedef struct {
    tdec_pkg::coll_in_t pair;
    bit has_exp;
    tdec_pkg::coll_out_t exp;
  } pair_row_t;

  pair_row_t dir_rows[$];

  function automatic tdec_pkg::coll_in_t mk_pair(longint pax, longint paz, longint vax,
                                                 longint vaz, longint pbx, longint pbz,
                                                 longint vbx, longint vbz,
                                                 int ma, int mb, int ra, int rb);
    tdec_pkg::coll_in_t p;
    p.pos_a_x = 24'(pax); p.pos_a_z = 24'(paz); p.vel_a_x = 24'(vax); p.vel_a_z = 24'(vaz);
    p.pos_b_x = 24'(pbx); p.pos_b_z = 24'(pbz); p.vel_b_x = 24'(vbx); p.vel_b_z = 24'(vbz);
    p.mass_a = 16'(ma); p.mass_b = 16'(mb); p.radius_a = 16'(ra); p.radius_b = 16'(rb);
    return p;
  endfunction

  function automatic tdec_pkg::coll_out_t passthru(tdec_pkg::coll_in_t p);
    tdec_pkg::coll_out_t o;
    o.new_pos_a_x = p.pos_a_x; o.new_pos_a_z = p.pos_a_z;
    o.new_vel_a_x = p.vel_a_x; o.new_vel_a_z = p.vel_a_z;
    o.new_pos_b_x = p.pos_b_x; o.new_pos_b_z = p.pos_b_z;
    o.new_vel_b_x = p.vel_b_x; o.new_vel_b_z = p.vel_b_z;
    o.in_contact = 1'b0; o.impulse_applied = 1'b0;
    return o;
  endfunction

  function automatic void add_row(tdec_pkg::coll_in_t p, bit far_apart);
    pair_row_t r;
    r.pair = p;
    r.has_exp = far_apart;
    r.exp = passthru(p);
    dir_rows.push_back(r);
  endfunction

  // random pair: mostly near contact, some wide-range noise
  function automatic tdec_pkg::coll_in_t rand_pair();
    tdec_pkg::coll_in_t p;
    int mode = $urandom_range(0, 9);
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (mode < 7) begin
      p.radius_a = 16'($urandom_range(0, 65535));
      p.radius_b = 16'($urandom_range(0, 65535));
      p.pos_b_x = 24'(p.pos_a_x + $signed($urandom_range(0, 262143)) - 131072);
      p.pos_b_z = 24'(p.pos_a_z + $signed($urandom_range(0, 262143)) - 131072);
      if (mode == 0) p.pos_b_z = p.pos_a_z;
      if (mode == 1) begin
        p.pos_b_x = p.pos_a_x; p.pos_b_z = p.pos_a_z;
      end
      if ($urandom_range(0, 1)) begin
        p.vel_a_x = $signed(p.vel_a_x) >>> $urandom_range(0, 12);
        p.vel_a_z = $signed(p.vel_a_z) >>> $urandom_range(0, 12);
        p.vel_b_x = $signed(p.vel_b_x) >>> $urandom_range(0, 12);
        p.vel_b_z = $signed(p.vel_b_z) >>> $urandom_range(0, 12);
      end
    end
    if ($urandom_range(0, 3) == 0) p.mass_a = 16'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) p.mass_b = 16'($urandom_range(0, 3));
    return p;
  endfunction

  // valid stays high across back-to-back beats; it drops only for a gap
  task automatic send_pair(tdec_pkg::coll_in_t p);
    int gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    expected_q.push_back(collide(p, scale_q));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_q = v;
  endtask

  task automatic check_beat(tdec_pkg::coll_out_t got);
    tdec_pkg::coll_out_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat %p", got);
      return;
    end
    want = expected_q.pop_front();
    results_seen++;
    contacts_seen += got.in_contact;
    impulses_seen += got.impulse_applied;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("beat %0d: exp %p got %p", results_seen, want, got);
    end
  endtask

  // directed expectation for far-apart rows overrides the predictor
  int dir_check_left = 0;
  tdec_pkg::coll_out_t dir_exp_q[$];

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (dir_check_left > 0 && dir_exp_q.size() != 0 && expected_q.size() != 0) begin
        expected_q[0] = dir_exp_q.pop_front();
        dir_check_left--;
      end
      check_beat(out_data);
    end
  end

  // output stall: random holds per beat, one long hold-off on request
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [15:0] scales[5] = '{16'd0, 16'd65535, 16'd4096, 16'd9216, 16'd12000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // far apart, the first two at coordinate extremes: pure passthrough
    add_row(mk_pair(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 65535, 1, 0, 0), 1);
    add_row(mk_pair(CMAX, 0, 0, 0, CMIN, 0, 0, 0, 1, 65535, 65535, 65535), 1);
    add_row(mk_pair(0, 0, 100, 0, 24'sh400000, 0, 0, 0, 256, 256, 1000, 1000), 1);
    // coincident centres
    add_row(mk_pair(0, 0, 65536, 0, 0, 0, -65536, 0, 256, 256, 1000, 1000), 0);
    add_row(mk_pair(5000, -7000, 0, 0, 5000, -7000, 0, 0, 0, 0, 65535, 65535), 0);
    // head-on, overlapping, equal masses
    add_row(mk_pair(0, 0, 65536, 0, 1500, 0, -65536, 0, 256, 256, 1000, 1000), 0);
    // contact without overlap, approaching
    add_row(mk_pair(0, 0, 0, 20000, 0, 3000, 0, -20000, 256, 512, 1000, 1000), 0);
    // separating, overlapping
    add_row(mk_pair(0, 0, -65536, 0, 1000, 1000, 65536, 0, 256, 256, 1000, 1000), 0);
    // diagonal, zero and tiny masses, huge velocities to saturate; then a near pair at CMIN and a zero-radius pair
    add_row(mk_pair(0, 0, CMAX, CMAX, 700, 700, CMIN, CMIN, 0, 65535, 800, 800), 0);
    add_row(mk_pair(CMAX, CMAX, CMAX, 0, CMAX - 10, CMAX - 10, CMIN, 0, 1, 0,
                    65535, 65535), 0);
    add_row(mk_pair(CMIN, CMIN, 0, 0, CMIN + 5, CMIN, 0, 0, 100, 100, 65535, 65535), 0);
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 256, 256, 0, 0), 1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        // far-apart rows are checked against their typed value
        while (expected_q.size() != 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        dir_exp_q.push_back(dir_rows[i].exp);
        dir_check_left++;
      end
      send_pair(dir_rows[i].pair);
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_scale(scales[ph]);
      for (int k = 0; k < N_RAND / 5; k++) begin
        if (ph == 2 && k == 40) hold_long = 1'b1;
        send_pair(rand_pair());
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d result beats checked, %0d in contact, %0d with impulse, 5 scale settings",
             results_seen, contacts_seen, impulses_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
